// ----- src/ffc_pkg.sv -----
// shared types, constants and codes for the full-convolution fir filter
// no dependencies; every other file of the block imports this package
package ffc_pkg;

  // filter dimensions
  localparam int TAPS        = 21;
  localparam int SAMPLE_BITS = 16;

  // field widths fixed by the item format
  localparam int VALUE_W = 16;
  localparam int IDX_W   = 5;
  localparam int OUT_W   = 37;

  // counter for the zero samples of the tail
  localparam int CNT_W = $clog2(TAPS);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [OUT_W-1:0]       acc_t;
  typedef logic        [IDX_W-1:0]       idx_t;
  typedef logic        [CNT_W-1:0]       cnt_t;

  // item operation codes
  typedef enum logic {
    OP_COEF_WR = 1'b0,
    OP_PUSH    = 1'b1
  } op_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_CALC
  } state_t;

  // controls broadcast from the sequencer to the tap chain
  typedef struct packed {
    logic    shift;
    sample_t shift_data;
    logic    launch;
    logic    coef_we;
    idx_t    coef_idx;
    sample_t coef_data;
    logic    last;
  } ctl_t;

endpackage

// ----- src/ffc_ifs.sv -----
// valid/ready channel interfaces for input items and result items
// depends on ffc_pkg for field widths
interface ffc_in_if;
  import ffc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [IDX_W-1:0]           coef_index;
  logic signed [VALUE_W-1:0]  value;
  logic                       last_sample;

  modport source (output valid, output operation, output coef_index, output value,
                  output last_sample, input ready);
  modport sink   (input valid, input operation, input coef_index, input value,
                  input last_sample, output ready);
endinterface

interface ffc_out_if;
  import ffc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  filtered;
  logic                     last_output;

  modport source (output valid, output filtered, output last_output, input ready);
  modport sink   (input valid, input filtered, input last_output, output ready);
endinterface

// ----- src/fir_filter_full_convolution.sv -----
// Streaming FIR filter giving the full convolution of each sample block.
// Input channel in_ch (valid/ready): an item either writes one coefficient
// (operation 0, coef_index below TAPS, otherwise ignored) or pushes one
// Q1.15 sample (operation 1). A push with last_sample set is followed by
// TAPS-1 zero samples, so a block of N samples yields N+TAPS-1 results.
// Result channel out_ch (valid/ready): filtered is the exact Q7.30 sum of
// coefficient times sample; last_output flags the final result of a block.
// A pushed sample enters a row of TAPS cells; a partial sum walks the row
// one cell per cycle into the result register, then on to the output register
// and out_ch. No new item is taken until the walk for the last one is done,
// tail outputs included.
// A result register and the output register part the row from out_ch: a
// new item is taken while a finished result still waits; while the
// receiver stalls with both full, the next partial sum is held back.
// Synchronous active-low reset clears coefficients, delay line and control.
// depends on ffc_pkg, ffc_ifs, ffc_cell and ffc_ctrl
module fir_filter_full_convolution (
  input  logic       clk,
  input  logic       rst_n,
  ffc_in_if.sink     in_ch,
  ffc_out_if.source  out_ch
);
  import ffc_pkg::*;

  ctl_t             ctl;
  sample_t          x_q    [TAPS];
  acc_t             psum_q [TAPS];
  logic [TAPS-1:0]  tok_q;
  logic             done;
  logic             res_valid_r;
  acc_t             res_data_r;
  logic             res_last_r;
  logic             out_valid_r;
  acc_t             out_data_r;
  logic             out_last_r;
  logic             out_load;

  // sequencer
  ffc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .done     (done),
    .res_free (!res_valid_r),
    .ctl      (ctl)
  );

  // tap chain
  for (genvar k = 0; k < TAPS; k++) begin : g_tap
    if (k == 0) begin : g_first
      ffc_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef_we   (ctl.coef_we && (32'(ctl.coef_idx) == k)),
        .coef_data (ctl.coef_data),
        .shift     (ctl.shift),
        .x_in      (ctl.shift_data),
        .x_out     (x_q[k]),
        .tok_in    (ctl.launch),
        .psum_in   ('0),
        .tok_out   (tok_q[k]),
        .psum_out  (psum_q[k])
      );
    end else begin : g_rest
      ffc_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef_we   (ctl.coef_we && (32'(ctl.coef_idx) == k)),
        .coef_data (ctl.coef_data),
        .shift     (ctl.shift),
        .x_in      (x_q[k-1]),
        .x_out     (x_q[k]),
        .tok_in    (tok_q[k-1]),
        .psum_in   (psum_q[k-1]),
        .tok_out   (tok_q[k]),
        .psum_out  (psum_q[k])
      );
    end
  end

  assign done = tok_q[TAPS-1];

  // result register, filled when the sum leaves the chain
  assign out_load = res_valid_r && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (done) begin
      res_valid_r <= 1'b1;
    end else if (out_load) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_data_r <= psum_q[TAPS-1];
      res_last_r <= ctl.last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_data_r;
      out_last_r <= res_last_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.filtered    = out_data_r;
  assign out_ch.last_output = out_last_r;

  // at most one partial sum walks the chain
  a_one_token : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_q))
    else $error("more than one partial sum in the tap chain");

  // a finished sum never lands on an occupied result register
  a_res_free : assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !res_valid_r)
    else $error("sum left the chain while the result register was full");

  // a sample transfer closes the input
  a_push_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.operation == OP_PUSH) |=> !in_ch.ready)
    else $error("input reopened right after a sample transfer");

  // the chain never shifts while a partial sum is in flight
  a_no_shift : assert property (@(posedge clk) disable iff (!rst_n)
    (|tok_q[TAPS-2:0]) |-> !ctl.shift)
    else $error("delay line shifted during a sum");

endmodule

// ----- src/ffc_cell.sv -----
// one tap of the chain: coefficient, delayed sample and partial-sum stage
// depends on ffc_pkg
module ffc_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             coef_we,
  input  ffc_pkg::sample_t coef_data,
  input  logic             shift,
  input  ffc_pkg::sample_t x_in,
  output ffc_pkg::sample_t x_out,
  input  logic             tok_in,
  input  ffc_pkg::acc_t    psum_in,
  output logic             tok_out,
  output ffc_pkg::acc_t    psum_out
);
  import ffc_pkg::*;

  sample_t                       h_r;
  sample_t                       x_r;
  logic                          tok_r;
  acc_t                          psum_r;
  logic signed [2*SAMPLE_BITS-1:0] prod;

  // tap product, sign extended to the sum width
  assign prod = h_r * x_r;

  // coefficient and sample storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= '0;
      x_r <= '0;
    end else begin
      if (coef_we) begin
        h_r <= coef_data;
      end
      if (shift) begin
        x_r <= x_in;
      end
    end
  end

  // token marks the partial sum moving down the chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_in;
    end
  end

  // partial sum stage
  always_ff @(posedge clk) begin
    if (tok_in) begin
      psum_r <= psum_in + acc_t'(prod);
    end
  end

  assign x_out    = x_r;
  assign tok_out  = tok_r;
  assign psum_out = psum_r;

endmodule

// ----- src/ffc_ctrl.sv -----
// sequencer: takes items, writes coefficients, shifts samples and the tail zeros
// depends on ffc_pkg and ffc_in_if
module ffc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  ffc_in_if.sink        in_ch,
  input  logic          done,
  input  logic          res_free,
  output ffc_pkg::ctl_t ctl
);
  import ffc_pkg::*;

  state_t state_r, state_nxt;
  cnt_t   flush_cnt_r, flush_cnt_nxt;
  logic   final_r, final_nxt;
  logic   is_push;
  logic   idx_ok;

  assign is_push = (in_ch.operation == OP_PUSH);
  assign idx_ok  = (32'(in_ch.coef_index) < TAPS);

  // next state
  always_comb begin
    state_nxt     = state_r;
    flush_cnt_nxt = flush_cnt_r;
    final_nxt     = final_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid && is_push) begin
          state_nxt     = ST_LAUNCH;
          flush_cnt_nxt = in_ch.last_sample ? CNT_W'(TAPS - 1) : '0;
          final_nxt     = 1'b0;
        end
      end
      ST_LAUNCH: begin
        if (res_free) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (done) begin
          if (flush_cnt_r != '0) begin
            state_nxt     = ST_LAUNCH;
            flush_cnt_nxt = flush_cnt_r - 1'b1;
            final_nxt     = (flush_cnt_r == cnt_t'(1));
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready    = (state_r == ST_IDLE);
    ctl            = '0;
    ctl.coef_idx   = in_ch.coef_index;
    ctl.coef_data  = sample_t'(in_ch.value);
    ctl.last       = final_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (is_push) begin
            ctl.shift      = 1'b1;
            ctl.shift_data = sample_t'(in_ch.value);
          end else begin
            ctl.coef_we = idx_ok;
          end
        end
      end
      ST_LAUNCH: begin
        ctl.launch = res_free;
      end
      ST_CALC: begin
        // shift in one tail zero per output
        if (done && flush_cnt_r != '0) begin
          ctl.shift      = 1'b1;
          ctl.shift_data = '0;
        end
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      flush_cnt_r <= '0;
      final_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      flush_cnt_r <= flush_cnt_nxt;
      final_r     <= final_nxt;
    end
  end

endmodule
